// ===== rtl/ctvp_pkg.sv =====
// Shared types, constants and the arctangent table for the circle track vertex block.
// No dependencies; every other file imports this package.
package ctvp_pkg;

   localparam int PHASE_W  = 32;
   localparam int CORDIC_W = 36;
   localparam logic [PHASE_W-1:0] HALF_TURN = 32'h8000_0000;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_ORIGIN = 2'd1,
      STATUS_FLAT   = 2'd2
   } status_type;

   // atan(2^-i) as a phase, 2^32 = 2*pi
   function automatic logic [PHASE_W-1:0] atan_phase(input int idx);
      logic [PHASE_W-1:0] p;
      case (idx)
         0:  p = 32'h20000000;
         1:  p = 32'h12E4051E;
         2:  p = 32'h09FB385B;
         3:  p = 32'h051111D4;
         4:  p = 32'h028B0D43;
         5:  p = 32'h0145D7E1;
         6:  p = 32'h00A2F61E;
         7:  p = 32'h00517C55;
         8:  p = 32'h0028BE53;
         9:  p = 32'h00145F2F;
         10: p = 32'h000A2F98;
         11: p = 32'h000517CC;
         12: p = 32'h00028BE6;
         13: p = 32'h000145F3;
         14: p = 32'h0000A2F9;
         15: p = 32'h0000517C;
         16: p = 32'h000028BE;
         17: p = 32'h0000145F;
         18: p = 32'h00000A2F;
         19: p = 32'h00000517;
         20: p = 32'h0000028B;
         21: p = 32'h00000145;
         22: p = 32'h000000A2;
         23: p = 32'h00000051;
         24: p = 32'h00000028;
         25: p = 32'h00000014;
         26: p = 32'h0000000A;
         27: p = 32'h00000005;
         28: p = 32'h00000002;
         29: p = 32'h00000001;
         default: p = 32'h00000000;
      endcase
      return p;
   endfunction

   typedef struct packed {
      status_type         status;
      logic signed [31:0] curvature;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
   } hit_pay_type;

   typedef struct packed {
      status_type         status;
      logic               decr;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [31:0]        cmag;
      logic [31:0]        ax;
      logic [31:0]        ay;
   } root_pay_type;

   typedef struct packed {
      status_type         status;
      logic               decr;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [31:0]        cmag;
   } ratio_pay_type;

   typedef struct packed {
      status_type         status;
      logic               decr;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [32:0]        rx;
      logic [32:0]        ry;
   } offs_pay_type;

   typedef struct packed {
      status_type         status;
      logic               decr;
      logic signed [31:0] near_x;
      logic signed [31:0] near_y;
   } tan_pay_type;

endpackage

// ===== rtl/ctvp_cordic.sv =====
// Pipelined CORDIC vectoring unit: phase of (x, y), one iteration per stage, side payload.
// Depends on ctvp_pkg.
module ctvp_cordic import ctvp_pkg::*; #(
   parameter int LANES      = 1,
   parameter int ITERATIONS = 16,
   parameter int PAY_W      = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [CORDIC_W-1:0] in_y [LANES],
   input  logic signed [CORDIC_W-1:0] in_x [LANES],
   input  logic [PAY_W-1:0]           in_pay,
   output logic                       out_valid,
   output logic [PHASE_W-1:0]         out_phase [LANES],
   output logic [PAY_W-1:0]           out_pay
);

   logic                       vld_ff [0:ITERATIONS];
   logic [PAY_W-1:0]           pay_ff [0:ITERATIONS];
   logic [PHASE_W-1:0]         z_ff   [0:ITERATIONS][LANES];
   logic signed [CORDIC_W-1:0] x_ff   [0:ITERATIONS-1][LANES];
   logic signed [CORDIC_W-1:0] y_ff   [0:ITERATIONS-1][LANES];
   logic                       zf_ff  [0:ITERATIONS-1][LANES];

   // pre-rotation into the right half plane; a zero y is final right away
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      pay_ff[0] <= in_pay;
      for (int l = 0; l < LANES; l++) begin
         zf_ff[0][l] <= (in_y[l] == '0);
         if (in_x[l] < 0) begin
            x_ff[0][l] <= -in_x[l];
            y_ff[0][l] <= -in_y[l];
            z_ff[0][l] <= HALF_TURN;
         end else begin
            x_ff[0][l] <= in_x[l];
            y_ff[0][l] <= in_y[l];
            z_ff[0][l] <= '0;
         end
      end
   end

   for (genvar i = 1; i <= ITERATIONS; i++) begin : g_iter
      logic [PHASE_W-1:0] z_in [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (zf_ff[i-1][l]) begin
               z_in[l] = z_ff[i-1][l];
            end else if (y_ff[i-1][l] > 0) begin
               z_in[l] = z_ff[i-1][l] + atan_phase(i-1);
            end else begin
               z_in[l] = z_ff[i-1][l] - atan_phase(i-1);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_ff[i-1];
         end
         pay_ff[i] <= pay_ff[i-1];
         for (int l = 0; l < LANES; l++) begin
            z_ff[i][l] <= z_in[l];
         end
      end

      if (i < ITERATIONS) begin : g_keep
         logic signed [CORDIC_W-1:0] x_in [LANES];
         logic signed [CORDIC_W-1:0] y_in [LANES];

         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               if (zf_ff[i-1][l]) begin
                  x_in[l] = x_ff[i-1][l];
                  y_in[l] = y_ff[i-1][l];
               end else if (y_ff[i-1][l] > 0) begin
                  x_in[l] = x_ff[i-1][l] + (y_ff[i-1][l] >>> (i-1));
                  y_in[l] = y_ff[i-1][l] - (x_ff[i-1][l] >>> (i-1));
               end else begin
                  x_in[l] = x_ff[i-1][l] - (y_ff[i-1][l] >>> (i-1));
                  y_in[l] = y_ff[i-1][l] + (x_ff[i-1][l] >>> (i-1));
               end
            end
         end

         always_ff @(posedge clock) begin
            for (int l = 0; l < LANES; l++) begin
               x_ff[i][l]  <= x_in[l];
               y_ff[i][l]  <= y_in[l];
               zf_ff[i][l] <= zf_ff[i-1][l];
            end
         end
      end
   end

   assign out_valid = vld_ff[ITERATIONS];
   assign out_pay   = pay_ff[ITERATIONS];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_phase[l] = z_ff[ITERATIONS][l];
      end
   end

endmodule

// ===== rtl/ctvp_div2.sv =====
// Pipelined restoring divider, two numerators over one divisor, one quotient bit per stage.
// Depends on ctvp_pkg; in_hi must be below in_den.
module ctvp_div2 import ctvp_pkg::*; #(
   parameter int DEN_W = 32,
   parameter int QUO_W = 33,
   parameter int PAY_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_den,
   input  logic [DEN_W-1:0] in_hi [2],
   input  logic [QUO_W-1:0] in_lo [2],
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo [2],
   output logic [PAY_W-1:0] out_pay
);

   logic             vld_ff  [0:QUO_W];
   logic [PAY_W-1:0] pay_ff  [0:QUO_W];
   logic [QUO_W-1:0] work_ff [0:QUO_W][2];
   logic [DEN_W-1:0] rem_ff  [0:QUO_W-1][2];
   logic [DEN_W-1:0] den_ff  [0:QUO_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      pay_ff[0] <= in_pay;
      den_ff[0] <= in_den;
      for (int l = 0; l < 2; l++) begin
         rem_ff[0][l]  <= in_hi[l];
         work_ff[0][l] <= in_lo[l];
      end
   end

   // work holds the numerator bits still to come, quotient bits shift in below them
   for (genvar j = 1; j <= QUO_W; j++) begin : g_step
      logic [DEN_W:0]   rem_sh  [2];
      logic             ge      [2];
      logic [QUO_W-1:0] work_in [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            rem_sh[l]  = {rem_ff[j-1][l], work_ff[j-1][l][QUO_W-1]};
            ge[l]      = (rem_sh[l] >= {1'b0, den_ff[j-1]});
            work_in[l] = {work_ff[j-1][l][QUO_W-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_ff[j-1];
         end
         pay_ff[j] <= pay_ff[j-1];
         for (int l = 0; l < 2; l++) begin
            work_ff[j][l] <= work_in[l];
         end
      end

      if (j < QUO_W) begin : g_keep
         logic [DEN_W:0] diff [2];
         logic [DEN_W-1:0] rem_in [2];

         always_comb begin
            for (int l = 0; l < 2; l++) begin
               diff[l]   = rem_sh[l] - {1'b0, den_ff[j-1]};
               rem_in[l] = ge[l] ? diff[l][DEN_W-1:0] : rem_sh[l][DEN_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            den_ff[j] <= den_ff[j-1];
            for (int l = 0; l < 2; l++) begin
               rem_ff[j][l] <= rem_in[l];
            end
         end
      end
   end

   assign out_valid  = vld_ff[QUO_W];
   assign out_pay    = pay_ff[QUO_W];
   assign out_quo[0] = work_ff[QUO_W][0];
   assign out_quo[1] = work_ff[QUO_W][1];

endmodule

// ===== rtl/circle_track_vertex_and_phi.sv =====
// Each request passes through two CORDIC pipelines, the square root and two dividers.
// Throughput: one request per cycle; busy is always low.
// Reset clears every valid bit and drops requests in flight.
// Results carry no back-pressure: rsp_valid marks each result for one cycle.
// Depends on ctvp_pkg, ctvp_cordic, ctvp_div2.
module circle_track_vertex_and_phi import ctvp_pkg::*; #(
   parameter int ANGLE_ITERATIONS       = 16,
   parameter int POSITION_FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_curvature,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_hit0_x,
   input  logic signed [31:0] req_hit0_y,
   input  logic signed [31:0] req_hit1_x,
   input  logic signed [31:0] req_hit1_y,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_near_x,
   output logic signed [31:0] rsp_near_y,
   output logic signed [15:0] rsp_track_angle,
   output logic [1:0]         rsp_status
);

   localparam int OFS_W   = POSITION_FRACTION_BITS + 25;
   localparam int OFS_SHL = POSITION_FRACTION_BITS - 8;
   localparam logic [63:0] OFFSET_CAP = 64'd1 << 34;
   localparam logic signed [33:0] HALF_S = 34'sd2147483648;
   localparam logic signed [36:0] POS_MAX = 37'sd2147483647;
   localparam logic signed [36:0] NEG_MIN = -37'sd2147483648;

   assign busy = 1'b0;

   // ---------------- input register
   logic               s0_v_ff;
   logic signed [31:0] s0_c_ff, s0_x0_ff, s0_y0_ff;
   logic signed [31:0] s0_h0x_ff, s0_h0y_ff, s0_h1x_ff, s0_h1y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= start;
      end
      s0_c_ff   <= req_curvature;
      s0_x0_ff  <= req_center_x;
      s0_y0_ff  <= req_center_y;
      s0_h0x_ff <= req_hit0_x;
      s0_h0y_ff <= req_hit0_y;
      s0_h1x_ff <= req_hit1_x;
      s0_h1y_ff <= req_hit1_y;
   end

   status_type                 s0_status;
   hit_pay_type                hit_pay_in, hit_pay_out;
   logic signed [CORDIC_W-1:0] hit_y [2];
   logic signed [CORDIC_W-1:0] hit_x [2];
   logic [PHASE_W-1:0]         hit_phase [2];
   logic                       hit_v;
   logic [$bits(hit_pay_type)-1:0] hit_pay_bits;

   always_comb begin
      if (s0_x0_ff == '0 && s0_y0_ff == '0) begin
         s0_status = STATUS_ORIGIN;
      end else if (s0_c_ff == '0) begin
         s0_status = STATUS_FLAT;
      end else begin
         s0_status = STATUS_OK;
      end
      hit_pay_in.status    = s0_status;
      hit_pay_in.curvature = s0_c_ff;
      hit_pay_in.center_x  = s0_x0_ff;
      hit_pay_in.center_y  = s0_y0_ff;
      hit_y[0] = CORDIC_W'($signed({s0_h0y_ff[31], s0_h0y_ff})
                           - $signed({s0_y0_ff[31], s0_y0_ff}));
      hit_x[0] = CORDIC_W'($signed({s0_h0x_ff[31], s0_h0x_ff})
                           - $signed({s0_x0_ff[31], s0_x0_ff}));
      hit_y[1] = CORDIC_W'($signed({s0_h1y_ff[31], s0_h1y_ff})
                           - $signed({s0_y0_ff[31], s0_y0_ff}));
      hit_x[1] = CORDIC_W'($signed({s0_h1x_ff[31], s0_h1x_ff})
                           - $signed({s0_x0_ff[31], s0_x0_ff}));
   end

   ctvp_cordic #(
      .LANES      (2),
      .ITERATIONS (ANGLE_ITERATIONS),
      .PAY_W      ($bits(hit_pay_type))
   ) u_hit_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_v_ff),
      .in_y      (hit_y),
      .in_x      (hit_x),
      .in_pay    (hit_pay_in),
      .out_valid (hit_v),
      .out_phase (hit_phase),
      .out_pay   (hit_pay_bits)
   );

   assign hit_pay_out = hit_pay_type'(hit_pay_bits);

   // ---------------- hit direction, magnitudes
   logic signed [33:0] dphi;
   logic               decr;
   root_pay_type       n1_in;
   logic               n1_v_ff;
   root_pay_type       n1_ff;

   always_comb begin
      dphi = $signed({{2{hit_phase[1][31]}}, hit_phase[1]})
           - $signed({{2{hit_phase[0][31]}}, hit_phase[0]});
      // wrapped difference below zero; exactly -pi counts, +pi does not
      decr = (dphi < 0 && dphi >= -HALF_S) || (dphi > HALF_S);
      n1_in.status   = hit_pay_out.status;
      n1_in.decr     = decr;
      n1_in.center_x = hit_pay_out.center_x;
      n1_in.center_y = hit_pay_out.center_y;
      n1_in.cmag     = hit_pay_out.curvature[31] ? 32'(-hit_pay_out.curvature)
                                                 : 32'(hit_pay_out.curvature);
      n1_in.ax       = hit_pay_out.center_x[31] ? 32'(-hit_pay_out.center_x)
                                                : 32'(hit_pay_out.center_x);
      n1_in.ay       = hit_pay_out.center_y[31] ? 32'(-hit_pay_out.center_y)
                                                : 32'(hit_pay_out.center_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_v_ff <= 1'b0;
      end else begin
         n1_v_ff <= hit_v;
      end
      n1_ff <= n1_in;
   end

   // ---------------- normalize shift count
   logic [31:0]  max_mag;
   logic [4:0]   shift_in;
   logic         n2_v_ff;
   root_pay_type n2_ff;
   logic [4:0]   shift_ff;

   always_comb begin
      max_mag  = (n1_ff.ax > n1_ff.ay) ? n1_ff.ax : n1_ff.ay;
      shift_in = '0;
      for (int b = 0; b < 31; b++) begin
         if (max_mag[b]) begin
            shift_in = 5'(30 - b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n2_v_ff <= 1'b0;
      end else begin
         n2_v_ff <= n1_v_ff;
      end
      n2_ff    <= n1_ff;
      shift_ff <= shift_in;
   end

   logic         n3_v_ff;
   root_pay_type n3_in;
   root_pay_type n3_ff;

   always_comb begin
      n3_in    = n2_ff;
      n3_in.ax = n2_ff.ax << shift_ff;
      n3_in.ay = n2_ff.ay << shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n3_v_ff <= 1'b0;
      end else begin
         n3_v_ff <= n2_v_ff;
      end
      n3_ff <= n3_in;
   end

   // ---------------- squares
   logic         n4_v_ff;
   root_pay_type n4_ff;
   logic [63:0]  sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n4_v_ff <= 1'b0;
      end else begin
         n4_v_ff <= n3_v_ff;
      end
      n4_ff  <= n3_ff;
      sqx_ff <= 64'(n3_ff.ax) * 64'(n3_ff.ax);
      sqy_ff <= 64'(n3_ff.ay) * 64'(n3_ff.ay);
   end

   // ---------------- integer square root, one result bit per stage
   logic         sq_v_ff   [0:32];
   root_pay_type sq_pay_ff [0:32];
   logic [63:0]  sq_r_ff   [0:32];
   logic [63:0]  sq_n_ff   [0:31];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else begin
         sq_v_ff[0] <= n4_v_ff;
      end
      sq_pay_ff[0] <= n4_ff;
      sq_n_ff[0]   <= sqx_ff + sqy_ff;
      sq_r_ff[0]   <= '0;
   end

   for (genvar j = 1; j <= 32; j++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (64 - 2 * j);
      logic [64:0] trial;
      logic        ge;
      logic [63:0] r_in;

      always_comb begin
         trial = {1'b0, sq_r_ff[j-1]} + {1'b0, BIT};
         ge    = ({1'b0, sq_n_ff[j-1]} >= trial);
         r_in  = ge ? ((sq_r_ff[j-1] >> 1) + BIT) : (sq_r_ff[j-1] >> 1);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j] <= 1'b0;
         end else begin
            sq_v_ff[j] <= sq_v_ff[j-1];
         end
         sq_pay_ff[j] <= sq_pay_ff[j-1];
         sq_r_ff[j]   <= r_in;
      end

      if (j < 32) begin : g_keep
         logic [63:0] n_in;
         assign n_in = ge ? (sq_n_ff[j-1] - trial[63:0]) : sq_n_ff[j-1];
         always_ff @(posedge clock) begin
            sq_n_ff[j] <= n_in;
         end
      end
   end

   // ---------------- ratios |X0|/s and |Y0|/s with 32 fractional bits
   root_pay_type  sq_out;
   ratio_pay_type rt_pay_in, rt_pay_out;
   logic [31:0]   rt_hi [2];
   logic [32:0]   rt_lo [2];
   logic [32:0]   rt_quo [2];
   logic          rt_v;
   logic [$bits(ratio_pay_type)-1:0] rt_pay_bits;

   always_comb begin
      sq_out             = sq_pay_ff[32];
      rt_pay_in.status   = sq_out.status;
      rt_pay_in.decr     = sq_out.decr;
      rt_pay_in.center_x = sq_out.center_x;
      rt_pay_in.center_y = sq_out.center_y;
      rt_pay_in.cmag     = sq_out.cmag;
      rt_hi[0] = {1'b0, sq_out.ax[31:1]};
      rt_lo[0] = {sq_out.ax[0], 32'd0};
      rt_hi[1] = {1'b0, sq_out.ay[31:1]};
      rt_lo[1] = {sq_out.ay[0], 32'd0};
   end

   ctvp_div2 #(
      .DEN_W (32),
      .QUO_W (33),
      .PAY_W ($bits(ratio_pay_type))
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_v_ff[32]),
      .in_den    (sq_r_ff[32][31:0]),
      .in_hi     (rt_hi),
      .in_lo     (rt_lo),
      .in_pay    (rt_pay_in),
      .out_valid (rt_v),
      .out_quo   (rt_quo),
      .out_pay   (rt_pay_bits)
   );

   assign rt_pay_out = ratio_pay_type'(rt_pay_bits);

   // ---------------- offsets: ratio scaled by the radius
   offs_pay_type of_pay_in, of_pay_out;
   logic [31:0]  of_hi [2];
   logic [OFS_W-1:0] of_lo [2];
   logic [OFS_W-1:0] of_quo [2];
   logic         of_v;
   logic [$bits(offs_pay_type)-1:0] of_pay_bits;

   always_comb begin
      of_pay_in.status   = rt_pay_out.status;
      of_pay_in.decr     = rt_pay_out.decr;
      of_pay_in.center_x = rt_pay_out.center_x;
      of_pay_in.center_y = rt_pay_out.center_y;
      of_pay_in.rx       = rt_quo[0];
      of_pay_in.ry       = rt_quo[1];
      of_hi[0] = '0;
      of_hi[1] = '0;
      of_lo[0] = OFS_W'(rt_quo[0]) << OFS_SHL;
      of_lo[1] = OFS_W'(rt_quo[1]) << OFS_SHL;
   end

   ctvp_div2 #(
      .DEN_W (32),
      .QUO_W (OFS_W),
      .PAY_W ($bits(offs_pay_type))
   ) u_offset_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_v),
      .in_den    (rt_pay_out.cmag),
      .in_hi     (of_hi),
      .in_lo     (of_lo),
      .in_pay    (of_pay_in),
      .out_valid (of_v),
      .out_quo   (of_quo),
      .out_pay   (of_pay_bits)
   );

   assign of_pay_out = offs_pay_type'(of_pay_bits);

   // ---------------- candidate points
   logic [34:0]        offx, offy;
   logic               s6_v_ff;
   offs_pay_type       s6_pay_ff;
   logic signed [36:0] s6_xp_ff, s6_xm_ff, s6_yp_ff, s6_ym_ff;
   logic signed [36:0] x0_w, y0_w;

   always_comb begin
      offx = (64'(of_quo[0]) > OFFSET_CAP) ? 35'(OFFSET_CAP) : 35'(of_quo[0]);
      offy = (64'(of_quo[1]) > OFFSET_CAP) ? 35'(OFFSET_CAP) : 35'(of_quo[1]);
      x0_w = 37'(of_pay_out.center_x);
      y0_w = 37'(of_pay_out.center_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else begin
         s6_v_ff <= of_v;
      end
      s6_pay_ff <= of_pay_out;
      s6_xp_ff  <= x0_w + $signed({2'b00, offx});
      s6_xm_ff  <= x0_w - $signed({2'b00, offx});
      s6_yp_ff  <= y0_w + $signed({2'b00, offy});
      s6_ym_ff  <= y0_w - $signed({2'b00, offy});
   end

   // ---------------- choose the smaller magnitude, build the tangent vector
   logic [36:0]        mxp, mxm, myp, mym;
   logic               xplus, yplus;
   logic signed [36:0] nx, ny;
   logic signed [33:0] rx_s, ry_s;
   tan_pay_type        s7_in;
   logic               s7_v_ff;
   tan_pay_type        s7_pay_ff;
   logic signed [33:0] s7_tx_ff, s7_ty_ff;

   always_comb begin
      mxp   = s6_xp_ff[36] ? 37'(-s6_xp_ff) : 37'(s6_xp_ff);
      mxm   = s6_xm_ff[36] ? 37'(-s6_xm_ff) : 37'(s6_xm_ff);
      myp   = s6_yp_ff[36] ? 37'(-s6_yp_ff) : 37'(s6_yp_ff);
      mym   = s6_ym_ff[36] ? 37'(-s6_ym_ff) : 37'(s6_ym_ff);
      xplus = (mxp < mxm);
      yplus = (myp < mym);
      nx    = xplus ? s6_xp_ff : s6_xm_ff;
      ny    = yplus ? s6_yp_ff : s6_ym_ff;
      rx_s  = $signed({1'b0, s6_pay_ff.rx});
      ry_s  = $signed({1'b0, s6_pay_ff.ry});
      s7_in.status = s6_pay_ff.status;
      s7_in.decr   = s6_pay_ff.decr;
      if (nx > POS_MAX) begin
         s7_in.near_x = 32'sh7FFFFFFF;
      end else if (nx < NEG_MIN) begin
         s7_in.near_x = 32'sh80000000;
      end else begin
         s7_in.near_x = nx[31:0];
      end
      if (ny > POS_MAX) begin
         s7_in.near_y = 32'sh7FFFFFFF;
      end else if (ny < NEG_MIN) begin
         s7_in.near_y = 32'sh80000000;
      end else begin
         s7_in.near_y = ny[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else begin
         s7_v_ff <= s6_v_ff;
      end
      s7_pay_ff <= s7_in;
      s7_tx_ff  <= xplus ? rx_s : -rx_s;
      s7_ty_ff  <= yplus ? -ry_s : ry_s;
   end

   // ---------------- tangent azimuth
   logic signed [CORDIC_W-1:0] tan_y [1];
   logic signed [CORDIC_W-1:0] tan_x [1];
   logic [PHASE_W-1:0]         tan_phase [1];
   logic                       tan_v;
   logic [$bits(tan_pay_type)-1:0] tan_pay_bits;
   tan_pay_type                tan_out;

   assign tan_y[0] = CORDIC_W'(s7_tx_ff);
   assign tan_x[0] = CORDIC_W'(s7_ty_ff);

   ctvp_cordic #(
      .LANES      (1),
      .ITERATIONS (ANGLE_ITERATIONS),
      .PAY_W      ($bits(tan_pay_type))
   ) u_tan_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s7_v_ff),
      .in_y      (tan_y),
      .in_x      (tan_x),
      .in_pay    (s7_pay_ff),
      .out_valid (tan_v),
      .out_phase (tan_phase),
      .out_pay   (tan_pay_bits)
   );

   assign tan_out = tan_pay_type'(tan_pay_bits);

   // ---------------- result register
   logic [PHASE_W-1:0] phi;
   logic [15:0]        angle;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_near_x_ff, rsp_near_y_ff;
   logic signed [15:0] rsp_angle_ff;
   logic [1:0]         rsp_status_ff;

   always_comb begin
      phi   = tan_phase[0] + (tan_out.decr ? HALF_TURN : '0);
      angle = phi[31:16] + 16'(phi[15]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= tan_v;
      end
      rsp_status_ff <= tan_out.status;
      if (tan_out.status != STATUS_OK) begin
         rsp_near_x_ff <= '0;
         rsp_near_y_ff <= '0;
         rsp_angle_ff  <= '0;
      end else begin
         rsp_near_x_ff <= tan_out.near_x;
         rsp_near_y_ff <= tan_out.near_y;
         rsp_angle_ff  <= angle;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_near_x      = rsp_near_x_ff;
   assign rsp_near_y      = rsp_near_y_ff;
   assign rsp_track_angle = rsp_angle_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// ===== rtl/ctvp_chk.sv =====
// Port-level checks for circle_track_vertex_and_phi, attached by bind.
// Depends on ctvp_pkg and the top level's port list.
module ctvp_chk import ctvp_pkg::*; #(
   parameter int ANGLE_ITERATIONS       = 16,
   parameter int POSITION_FRACTION_BITS = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] req_curvature,
   input logic signed [31:0] req_center_x,
   input logic signed [31:0] req_center_y,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_near_x,
   input logic signed [31:0] rsp_near_y,
   input logic signed [15:0] rsp_track_angle,
   input logic [1:0]         rsp_status
);

   localparam int LAT = 103 + 2 * ANGLE_ITERATIONS + POSITION_FRACTION_BITS;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without a request");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ORIGIN
      |-> $past(req_center_x == 0 && req_center_y == 0, LAT))
      else $error("origin status on nonzero centre");

   a_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FLAT |-> $past(req_curvature == 0, LAT))
      else $error("flat status on nonzero curvature");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK
      |-> rsp_near_x == 0 && rsp_near_y == 0 && rsp_track_angle == 0)
      else $error("error result not cleared");

endmodule

bind circle_track_vertex_and_phi ctvp_chk #(
   .ANGLE_ITERATIONS       (ANGLE_ITERATIONS),
   .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
) u_ctvp_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_curvature   (req_curvature),
   .req_center_x    (req_center_x),
   .req_center_y    (req_center_y),
   .rsp_valid       (rsp_valid),
   .rsp_near_x      (rsp_near_x),
   .rsp_near_y      (rsp_near_y),
   .rsp_track_angle (rsp_track_angle),
   .rsp_status      (rsp_status)
);
